### src/photodiode_power_estimator_assert.svh
`ifndef PHOTODIODE_POWER_ESTIMATOR_ASSERT_SVH
`define PHOTODIODE_POWER_ESTIMATOR_ASSERT_SVH

// same-cycle implication, checked at every clock edge outside reset
`define PPE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ppe_pkg.sv
package ppe_pkg;

	// converter sample width
	localparam int ADC_BITS = 12;

	// fixed field widths
	localparam int CAL_W = 12;
	localparam int PWR_W = 16;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// arithmetic widths
	localparam int DIFF_W = ADC_BITS + 2;
	localparam int PROD_W = DIFF_W + PWR_W + 1;
	localparam int NUM_W = PROD_W + 1;
	localparam int DEN_S_W = CAL_W + 1;
	localparam int DEN_W = CAL_W;
	localparam int CMP_W = ((ADC_BITS > CAL_W + 1) ? ADC_BITS : CAL_W + 1) + 1;
	localparam int CNT_W = $clog2(NUM_W);

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

	// curve constants
	localparam logic [ADC_BITS-1:0] HELD_RST = ADC_BITS'(100);
	localparam logic signed [ADC_BITS:0] DB_LIM = 3;
	localparam logic [CMP_W-1:0] KNEE_UND = 200;
	localparam logic [CMP_W-1:0] KNEE_DIV = 130;
	localparam logic signed [DIFF_W-1:0] OFS_LOW = 200;
	localparam logic signed [DIFF_W-1:0] OFS_HIGH = 400;
	localparam logic signed [DIFF_W-1:0] OFS_DIV = 120;
	localparam logic signed [DEN_S_W-1:0] DEN_OFS_LOW = 200;
	localparam logic signed [DEN_S_W-1:0] DEN_OFS_HIGH = 400;
	localparam logic signed [NUM_W-1:0] HIGH_BIAS = 200;
	localparam logic [PWR_W-1:0] POWER_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ADC_AT_HIGH = 3'd0,
		REG_ADC_AT_LOW = 3'd1,
		REG_POWER_AT_HIGH = 3'd2,
		REG_POWER_AT_LOW = 3'd3,
		REG_UNDIVIDED_MODE = 3'd4
	} cfg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK = 2'd0,
		STAT_DIV_ZERO = 2'd1,
		STAT_CLAMP = 2'd2
	} status_t;

	typedef struct packed {
		logic [CAL_W-1:0] adc_at_high;
		logic [CAL_W-1:0] adc_at_low;
		logic [PWR_W-1:0] power_at_high;
		logic [PWR_W-1:0] power_at_low;
		logic undivided_mode;
	} cfg_t;

	localparam cfg_t CFG_RST = '{
		adc_at_high: 12'd3686,
		adc_at_low: 12'd410,
		power_at_high: 16'd1800,
		power_at_low: 16'd200,
		undivided_mode: 1'b1
	};

	typedef enum logic [2:0] {
		S_IDLE,
		S_DBAND,
		S_SEL,
		S_MUL,
		S_ADD,
		S_ABS,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic dband;
		logic sel;
		logic mul;
		logic add;
		logic abs_init;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic skip_div;
	} dp_stat_t;

endpackage

### src/photodiode_power_estimator.sv
// channel   direction  handshake              payload
// input     in         in_valid / in_stall    adc_sample
// result    out        out_valid / out_stall  power_estimate, status
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an item runs from accept to result valid through deadband, select, multiply,
// add, sign split and the restoring divider, which retires one quotient bit a cycle;
// items landing in a zero region or with a zero divisor skip the divider
// the next item is accepted once the previous one sits in the output
// register, even while out_stall holds it
// arst_n resets control, calibration registers and the held sample (100)
// cfg_ready is always high; writes are meant only while the block is idle
module photodiode_power_estimator (
	input logic clk,
	input logic arst_n,
	// input channel
	input logic in_valid,
	output logic in_stall,
	input logic [ppe_pkg::ADC_BITS-1:0] adc_sample,
	// result channel
	output logic out_valid,
	input logic out_stall,
	output logic [ppe_pkg::PWR_W-1:0] power_estimate,
	output logic [ppe_pkg::STATUS_W-1:0] status,
	// configuration write channel
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ppe_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ppe_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ppe_pkg::*;

	// calibration registers
	cfg_t cfg;
	// controller commands and datapath feedback
	cmd_t cmd;
	dp_stat_t stat;

	// register file for the five calibration settings
	ppe_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// sequencer: deadband, segment select, multiply, add, sign split,
	// divide iterations, then load of the output register
	ppe_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat(stat),
		.cmd(cmd)
	);

	// held sample, operand registers, multiplier, divider, output register
	ppe_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg(cfg),
		.adc_sample(adc_sample),
		.stat(stat),
		.power_estimate(power_estimate),
		.status(status)
	);

endmodule

### src/ppe_cfg.sv
module ppe_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ppe_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ppe_pkg::CFG_DATA_W-1:0] cfg_data,
	output ppe_pkg::cfg_t cfg
);
	import ppe_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// unknown indexes are dropped, upper data bits ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_ADC_AT_HIGH: cfg_q.adc_at_high <= cfg_data[CAL_W-1:0];
				REG_ADC_AT_LOW: cfg_q.adc_at_low <= cfg_data[CAL_W-1:0];
				REG_POWER_AT_HIGH: cfg_q.power_at_high <= cfg_data[PWR_W-1:0];
				REG_POWER_AT_LOW: cfg_q.power_at_low <= cfg_data[PWR_W-1:0];
				REG_UNDIVIDED_MODE: cfg_q.undivided_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

### src/ppe_dp.sv
module ppe_dp (
	input logic clk,
	input logic arst_n,
	input ppe_pkg::cmd_t cmd,
	input ppe_pkg::cfg_t cfg,
	input logic [ppe_pkg::ADC_BITS-1:0] adc_sample,
	output ppe_pkg::dp_stat_t stat,
	output logic [ppe_pkg::PWR_W-1:0] power_estimate,
	output logic [ppe_pkg::STATUS_W-1:0] status
);
	import ppe_pkg::*;

	logic [ADC_BITS-1:0] held_q;
	logic [ADC_BITS-1:0] samp_q;
	logic [ADC_BITS-1:0] v_q;
	logic zero_q;
	logic seg3_q;
	logic signed [DIFF_W-1:0] a_q;
	logic [PWR_W-1:0] b_q;
	logic signed [DEN_S_W-1:0] d_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [NUM_W-1:0] addc_q;
	logic signed [NUM_W-1:0] n_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic neg_q;
	logic [PWR_W-1:0] power_q;
	status_t status_q;

	// deadband
	logic signed [ADC_BITS:0] db_diff;
	logic db_hold;

	always_comb begin
		db_diff = $signed({1'b0, samp_q}) - $signed({1'b0, held_q});
		db_hold = (db_diff > -DB_LIM) && (db_diff < DB_LIM);
	end

	// segment selection and operands
	logic [CMP_W-1:0] v_cmp;
	logic [CMP_W-1:0] lo_knee;
	logic signed [DIFF_W-1:0] v_s;
	logic sel_zero;
	logic sel_seg3;
	logic signed [DIFF_W-1:0] sel_a;
	logic [PWR_W-1:0] sel_b;
	logic signed [DEN_S_W-1:0] sel_d;

	always_comb begin
		v_cmp = CMP_W'(v_q);
		lo_knee = CMP_W'(cfg.adc_at_low) + KNEE_UND;
		v_s = $signed({2'b00, v_q});
		if (cfg.undivided_mode) begin
			sel_zero = (v_cmp <= KNEE_UND);
			sel_seg3 = (v_cmp > lo_knee);
			if (sel_seg3) begin
				sel_a = v_s - OFS_HIGH;
				sel_b = cfg.power_at_high;
				sel_d = $signed({1'b0, cfg.adc_at_high}) - DEN_OFS_HIGH;
			end else begin
				sel_a = v_s - OFS_LOW;
				sel_b = cfg.power_at_low;
				sel_d = $signed({1'b0, cfg.adc_at_low}) - DEN_OFS_LOW;
			end
		end else begin
			sel_zero = (v_cmp < KNEE_DIV);
			sel_seg3 = 1'b0;
			sel_a = v_s - OFS_DIV;
			sel_b = {1'b0, cfg.power_at_high[PWR_W-1:1]};
			sel_d = $signed({2'b00, cfg.adc_at_high[CAL_W-1:1]});
		end
	end

	// multiply, offset term, add
	logic signed [PROD_W-1:0] prod_c;
	logic signed [NUM_W-1:0] addc_c;
	logic signed [NUM_W-1:0] n_c;

	always_comb begin
		prod_c = PROD_W'(a_q) * PROD_W'($signed({1'b0, b_q}));
		addc_c = seg3_q ? NUM_W'(d_q) * HIGH_BIAS : '0;
		n_c = NUM_W'(prod_q) + addc_q;
	end

	// sign and magnitude split for the divider
	logic signed [NUM_W-1:0] n_neg;
	logic signed [DEN_S_W-1:0] d_neg;
	logic [NUM_W-1:0] mag_c;
	logic [DEN_W-1:0] den_c;
	logic neg_c;

	always_comb begin
		n_neg = -n_q;
		d_neg = -d_q;
		mag_c = n_q[NUM_W-1] ? $unsigned(n_neg) : $unsigned(n_q);
		den_c = d_q[DEN_S_W-1] ? d_neg[DEN_W-1:0] : d_q[DEN_W-1:0];
		neg_c = n_q[NUM_W-1] ^ d_q[DEN_S_W-1];
	end

	assign stat.skip_div = zero_q || (d_q == '0);

	// restoring divide step
	logic [DEN_W:0] r_sh;
	logic [DEN_W:0] r_sub;
	logic r_ge;

	always_comb begin
		r_sh = {rem_q, quo_q[NUM_W-1]};
		r_sub = r_sh - {1'b0, den_q};
		r_ge = (r_sh >= {1'b0, den_q});
	end

	// result with clamping
	logic [PWR_W-1:0] fin_power;
	status_t fin_status;

	always_comb begin
		if (zero_q) begin
			fin_power = '0;
			fin_status = STAT_OK;
		end else if (d_q == '0) begin
			fin_power = '0;
			fin_status = STAT_DIV_ZERO;
		end else if (neg_q && (quo_q != '0)) begin
			fin_power = '0;
			fin_status = STAT_CLAMP;
		end else if (|quo_q[NUM_W-1:PWR_W]) begin
			fin_power = POWER_MAX;
			fin_status = STAT_CLAMP;
		end else begin
			fin_power = quo_q[PWR_W-1:0];
			fin_status = STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= HELD_RST;
		end else if (cmd.dband && !db_hold) begin
			held_q <= samp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			samp_q <= adc_sample;
		end
		if (cmd.dband) begin
			v_q <= db_hold ? held_q : samp_q;
		end
		if (cmd.sel) begin
			zero_q <= sel_zero;
			seg3_q <= sel_seg3;
			a_q <= sel_a;
			b_q <= sel_b;
			d_q <= sel_d;
		end
		if (cmd.mul) begin
			prod_q <= prod_c;
			addc_q <= addc_c;
		end
		if (cmd.add) begin
			n_q <= n_c;
		end
		if (cmd.abs_init) begin
			quo_q <= mag_c;
			rem_q <= '0;
			den_q <= den_c;
			neg_q <= neg_c;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[NUM_W-2:0], r_ge};
			rem_q <= r_ge ? r_sub[DEN_W-1:0] : r_sh[DEN_W-1:0];
		end
		if (cmd.load_out) begin
			power_q <= fin_power;
			status_q <= fin_status;
		end
	end

	assign power_estimate = power_q;
	assign status = status_q;

endmodule

### src/ppe_ctrl.sv
module ppe_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input ppe_pkg::dp_stat_t stat,
	output ppe_pkg::cmd_t cmd
);
	import ppe_pkg::*;

	state_t state_q;
	state_t state_d;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DBAND;
				end
			end
			S_DBAND: state_d = S_SEL;
			S_SEL: state_d = S_MUL;
			S_MUL: state_d = S_ADD;
			S_ADD: state_d = S_ABS;
			S_ABS: state_d = stat.skip_div ? S_DONE : S_DIV;
			S_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.capture = in_valid;
			end
			S_DBAND: cmd.dband = 1'b1;
			S_SEL: cmd.sel = 1'b1;
			S_MUL: cmd.mul = 1'b1;
			S_ADD: cmd.add = 1'b1;
			S_ABS: cmd.abs_init = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_DONE: cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ABS) begin
				cnt_q <= '0;
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### src/ppe_checker.sv
`include "photodiode_power_estimator_assert.svh"

module ppe_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [ppe_pkg::PWR_W-1:0] power_estimate,
	input logic [ppe_pkg::STATUS_W-1:0] status
);
	import ppe_pkg::*;

	// a stalled result holds
	`PPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(power_estimate) && $stable(status), "stalled result changed")

	// one item in flight: the block stalls right after an accept
	`PPE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted back to back")

	// only defined status codes leave the block
	`PPE_ASSERT_NOW(a_status_code, out_valid, status == STAT_OK || status == STAT_DIV_ZERO || status == STAT_CLAMP, "undefined status code")

	// clamping only ever lands on the range ends
	`PPE_ASSERT_NOW(a_clamp_value, out_valid && status == STAT_CLAMP, power_estimate == '0 || power_estimate == POWER_MAX, "clamped power off range end")

	// a zero divisor reports zero power
	`PPE_ASSERT_NOW(a_div_zero_value, out_valid && status == STAT_DIV_ZERO, power_estimate == '0, "zero divisor with nonzero power")

endmodule

bind photodiode_power_estimator ppe_checker u_ppe_checker (.*);
